// File: src/graph_reachability_check_defines.svh
// ----------------------------------------------------------------------------
// graph reachability check assertion macros
// shared property wrappers for the reachability block, clocked on aclk and
// disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef GRAPH_REACHABILITY_CHECK_DEFINES_SVH
`define GRAPH_REACHABILITY_CHECK_DEFINES_SVH

// same-cycle implication
`define GRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// item codes and verdict codes for the graph reachability check
// ----------------------------------------------------------------------------
`default_nettype none

package grc_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] verdict_t;

    localparam op_t OP_WR_COMPAT   = 2'd0;
    localparam op_t OP_WR_INCOMPAT = 2'd1;
    localparam op_t OP_QUERY       = 2'd2;

    localparam verdict_t V_SAME    = 2'd0;
    localparam verdict_t V_DIRECT  = 2'd1;
    localparam verdict_t V_REACH   = 2'd2;
    localparam verdict_t V_NOROUTE = 2'd3;

    localparam int NODE_ID_W = 5;
    localparam int MASK_W    = 32;

endpackage

`default_nettype wire

// File: src/graph_reachability_check.sv
// ----------------------------------------------------------------------------
// graph_reachability_check
// holds a compatible-edge matrix and an incompatibility matrix over a set of
// nodes and answers source/target queries by growing a visited set
// ----------------------------------------------------------------------------
// usage
//   s_ channel takes one item per handshake: write compatible row, write
//   incompatible row, or query a source/target pair. writes finish in the
//   cycle they are accepted and give no result. a query gives one verdict item
//   on the m_ channel.
//   a query takes a check step, which settles same-node, out-of-range and
//   directly incompatible pairs at once; other queries go on to expansion
//   passes of the visited set (at most min(NUM_NODES,32) passes, stopping
//   early once the set no longer grows). each query ends with a load of the
//   output register. the single expansion unit ORs the rows of all visited
//   nodes each pass. s_tready is low while a query is in progress; a write
//   does not drop it.
//   a finished verdict sits in the output register until taken; a new item is
//   accepted meanwhile, and a following query waits in its last cycle if the
//   receiver still stalls on the previous verdict.
//   reset (aresetn low, synchronous) clears both matrices to no edges and
//   drops any pending item.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_reachability_check
    import grc_pkg::*;
#(
    parameter int NUM_NODES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[1:0], first_licence[6:2], second_licence[11:7], row_mask[43:12]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // verdict[1:0]
    output logic [7:0]       m_tdata
);

    // at most the 32 nodes that the index fields can name are stored (ROW_W rows)
    localparam int ROW_W = (NUM_NODES < MASK_W) ? NUM_NODES : MASK_W;
    localparam int IDX_W = $clog2(ROW_W);
    localparam logic [NODE_ID_W:0] NODE_LIM = (NODE_ID_W + 1)'(ROW_W);
    localparam logic [IDX_W-1:0]   PASS_LAST = IDX_W'(ROW_W - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_EXPAND = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    op_t                  in_op;
    logic [NODE_ID_W-1:0] in_first;
    logic [NODE_ID_W-1:0] in_second;
    logic [MASK_W-1:0]    in_mask;
    logic                 in_row_ok;
    logic                 in_fire;

    state_t               state_reg, state_next;
    logic [NODE_ID_W-1:0] src_reg, src_next;
    logic [NODE_ID_W-1:0] dst_reg, dst_next;
    logic [ROW_W-1:0]     set_reg, set_next;
    logic [IDX_W-1:0]     pass_reg, pass_next;
    verdict_t             res_reg, res_next;
    verdict_t             verdict_reg, verdict_next;
    logic                 m_valid_reg, m_valid_next;

    logic [ROW_W-1:0]     compat_rows_reg [ROW_W];
    logic [ROW_W-1:0]     incompat_rows_reg [ROW_W];

    logic [IDX_W-1:0]     src_idx;
    logic [IDX_W-1:0]     dst_idx;
    logic                 src_ok;
    logic                 dst_ok;
    logic [ROW_W-1:0]     expand_set;
    logic                 out_free;

    assign in_op     = s_tdata[1:0];
    assign in_first  = s_tdata[6:2];
    assign in_second = s_tdata[11:7];
    assign in_mask   = s_tdata[43:12];
    assign in_row_ok = {1'b0, in_first} < NODE_LIM;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, verdict_reg};

    assign src_idx = src_reg[IDX_W-1:0];
    assign dst_idx = dst_reg[IDX_W-1:0];
    assign src_ok  = {1'b0, src_reg} < NODE_LIM;
    assign dst_ok  = {1'b0, dst_reg} < NODE_LIM;

    assign out_free = !m_valid_reg || m_tready;

    // one pass of the shared expansion unit: OR in the row of every visited node
    always_comb begin
        expand_set = set_reg;
        for (int i = 0; i < ROW_W; i++) begin
            if (set_reg[i]) begin
                expand_set = expand_set | compat_rows_reg[i];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        set_next     = set_reg;
        pass_next    = pass_reg;
        res_next     = res_reg;
        verdict_next = verdict_reg;
        m_valid_next = m_valid_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire && in_op == OP_QUERY) begin
                    src_next   = in_first;
                    dst_next   = in_second;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (src_reg == dst_reg) begin
                    res_next   = V_SAME;
                    state_next = S_OUT;
                end else if (!src_ok || !dst_ok) begin
                    res_next   = V_NOROUTE;
                    state_next = S_OUT;
                end else if (incompat_rows_reg[src_idx][dst_idx]) begin
                    res_next   = V_DIRECT;
                    state_next = S_OUT;
                end else begin
                    set_next   = {{(ROW_W-1){1'b0}}, 1'b1} << src_idx;
                    pass_next  = '0;
                    state_next = S_EXPAND;
                end
            end
            S_EXPAND: begin
                set_next  = expand_set;
                pass_next = pass_reg + 1'b1;
                if (expand_set == set_reg || pass_reg == PASS_LAST) begin
                    res_next   = expand_set[dst_idx] ? V_REACH : V_NOROUTE;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    verdict_next = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        set_reg     <= set_next;
        pass_reg    <= pass_next;
        res_reg     <= res_next;
        verdict_reg <= verdict_next;
    end

    // row writes land in the cycle the item is accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROW_W; i++) begin
                compat_rows_reg[i]   <= '0;
                incompat_rows_reg[i] <= '0;
            end
        end else if (in_fire && in_row_ok) begin
            if (in_op == OP_WR_COMPAT) begin
                compat_rows_reg[in_first[IDX_W-1:0]] <= in_mask[ROW_W-1:0];
            end else if (in_op == OP_WR_INCOMPAT) begin
                incompat_rows_reg[in_first[IDX_W-1:0]] <= in_mask[ROW_W-1:0];
            end
        end
    end

`include "graph_reachability_check_defines.svh"

    `GRC_ASSERT_SAME(a_src_visited, state_reg == S_EXPAND, set_reg[src_idx], "source left visited set")
    `GRC_ASSERT_NEXT(a_set_grows, state_reg == S_EXPAND && state_next == S_EXPAND, (set_reg & $past(set_reg)) == $past(set_reg), "visited set lost a node")
    `GRC_ASSERT_NEXT(a_query_check, in_fire && in_op == OP_QUERY, state_reg == S_CHECK, "accepted query did not start check")
    `GRC_ASSERT_NEXT(a_out_load, state_reg == S_OUT && out_free, m_valid_reg && verdict_reg == $past(res_reg), "verdict not loaded into output register")

endmodule

`default_nettype wire
